### rtl/size_class_free_list_allocator_top_defines.svh
// Assertion helpers for the allocator. Clock and reset are taken from the using scope.
`ifndef SIZE_CLASS_FREE_LIST_ALLOCATOR_TOP_DEFINES_SVH
`define SIZE_CLASS_FREE_LIST_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication.
`define SCLFL_ASSERT_NOW(label, prop_a, prop_c, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop_a) |-> (prop_c)) \
		else $error(msg);

// Next-cycle implication.
`define SCLFL_ASSERT_NEXT(label, prop_a, prop_c, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop_a) |=> (prop_c)) \
		else $error(msg);

`endif

### rtl/sclfl_pkg.sv
package sclfl_pkg;

	localparam int NUM_CLASSES  = 6;
	localparam int CFG_REGS     = 6;
	localparam int MAX_BLOCKS   = 256;
	localparam int IDX_W        = $clog2(MAX_BLOCKS);
	localparam int CNT_W        = IDX_W + 1;
	localparam int CLS_W        = 3;
	localparam int ADDR_W       = 18;
	localparam int REQ_W        = 16;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 9;
	localparam int STATUS_W     = 3;
	localparam int MIN_SHIFT    = 4;
	localparam int HEADER_BYTES = 4;
	localparam int MEM_DEPTH    = NUM_CLASSES * MAX_BLOCKS;
	localparam int MEM_AW       = $clog2(MEM_DEPTH);

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_ALLOC     = 3'd0,
		ST_FREED     = 3'd1,
		ST_ZERO      = 3'd2,
		ST_NO_BLOCK  = 3'd3,
		ST_BAD_ADDR  = 3'd4,
		ST_FULL      = 3'd5
	} status_t;

	typedef logic [CLS_W-1:0]  cls_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [ADDR_W-1:0] addr_t;

	// Pool layout, rebuilt after every configuration transaction to a class register.
	typedef struct packed {
		logic                      busy;
		logic                      load;
		addr_t                     total;
		addr_t [NUM_CLASSES-1:0]   base;
		addr_t [NUM_CLASSES-1:0]   lim;
		cnt_t  [NUM_CLASSES-1:0]   blocks;
	} layout_t;

	// Decoded request, captured into stage 1.
	typedef struct packed {
		status_t status;
		cls_t    cls;
		idx_t    idx;
		idx_t    pos;
		logic    mem_hit;
	} dec_t;

	function automatic addr_t class_size(input cls_t c);
		return addr_t'(1) << (MIN_SHIFT + int'(c));
	endfunction

endpackage

### rtl/sclfl_if.sv
interface sclfl_cmd_if import sclfl_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              operation;
	logic [REQ_W-1:0]  request_size;
	logic [ADDR_W-1:0] block_address;

	modport source(output valid, operation, request_size, block_address, input ready);
	modport sink(input valid, operation, request_size, block_address, output ready);
endinterface

interface sclfl_rsp_if import sclfl_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [ADDR_W-1:0]   user_address;
	logic [CLS_W-1:0]    size_class;
	logic [ADDR_W-1:0]   free_bytes;

	modport source(output valid, status, user_address, size_class, free_bytes, input ready);
	modport sink(input valid, status, user_address, size_class, free_bytes, output ready);
endinterface

interface sclfl_cfg_if import sclfl_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

### rtl/size_class_free_list_allocator_top.sv
// Channel  Role    Transaction
// cfg      sink    register index, block count
// cmd      sink    operation, request_size, block_address
// rsp      source  status, user_address, size_class, free_bytes
//
// An item is decoded in its accept cycle against the head and count registers, and
// the class ring memory is read in the same cycle; it then retires from stage 1 into
// the result register.
// Reset leaves an empty pool. Each configuration transaction to a class register starts a
// layout rebuild (one class per cycle) during which cmd.ready is low; writes to
// the spare indexes start none. The ring memory is not cleared.
// A retiring item waits while the result register holds an untaken result.
`include "size_class_free_list_allocator_top_defines.svh"

module size_class_free_list_allocator_top import sclfl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	sclfl_cfg_if.sink   cfg,
	sclfl_cmd_if.sink   cmd,
	sclfl_rsp_if.source rsp
);

	layout_t                lay;
	dec_t                   dec;
	idx_t [NUM_CLASSES-1:0] head_q;
	cnt_t [NUM_CLASSES-1:0] count_q;
	cnt_t [NUM_CLASSES-1:0] fill_q;
	addr_t                  free_total_q;

	logic    s1_valid_q;
	status_t status_s1;
	cls_t    cls_s1;
	idx_t    idx_s1;
	idx_t    pos_s1;
	logic    hit_s1;

	logic    out_valid_q;
	status_t status_q;
	addr_t   uaddr_q;
	cls_t    cls_q;
	addr_t   free_bytes_q;

	idx_t              rd_data;
	idx_t              blk;
	addr_t             size_s1;
	addr_t             uaddr_nx;
	addr_t             total_nx;
	logic [MEM_AW-1:0] rd_addr;
	logic [MEM_AW-1:0] wr_addr;
	logic              accept;
	logic              retire;
	logic              counts_ok;
	logic              rebuild_start;
	logic              alloc_out;

	assign cmd.ready = !s1_valid_q && !lay.busy;
	assign accept    = cmd.valid && cmd.ready;
	assign retire    = s1_valid_q && (!out_valid_q || rsp.ready);
	assign rd_addr   = MEM_AW'({dec.cls, dec.pos});
	assign wr_addr   = MEM_AW'({cls_s1, pos_s1});

	sclfl_layout u_layout (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.lay    (lay)
	);

	sclfl_decode u_decode (
		.operation     (cmd.operation),
		.request_size  (cmd.request_size),
		.block_address (cmd.block_address),
		.lay           (lay),
		.head          (head_q),
		.count         (count_q),
		.fill          (fill_q),
		.dec           (dec)
	);

	sclfl_ring_mem u_ring_mem (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (retire && status_s1 == ST_FREED),
		.wr_addr (wr_addr),
		.wr_data (idx_s1)
	);

	always_comb begin
		size_s1  = class_size(cls_s1);
		blk      = hit_s1 ? rd_data : pos_s1;
		uaddr_nx = '0;
		total_nx = free_total_q;
		case (status_s1)
			ST_ALLOC: begin
				uaddr_nx = lay.base[cls_s1] + (addr_t'(blk) << (MIN_SHIFT + int'(cls_s1)))
				         + addr_t'(HEADER_BYTES);
				total_nx = free_total_q - size_s1;
			end
			ST_FREED: begin
				total_nx = free_total_q + size_s1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (retire) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= dec.status;
			cls_s1    <= dec.cls;
			idx_s1    <= dec.idx;
			pos_s1    <= dec.pos;
			hit_s1    <= dec.mem_hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			count_q      <= '0;
			fill_q       <= '0;
			free_total_q <= '0;
		end else if (lay.load) begin
			head_q       <= '0;
			count_q      <= lay.blocks;
			fill_q       <= '0;
			free_total_q <= lay.total;
		end else if (retire) begin
			case (status_s1)
				ST_ALLOC: begin
					head_q[cls_s1]  <= head_q[cls_s1] + idx_t'(1);
					count_q[cls_s1] <= count_q[cls_s1] - cnt_t'(1);
					free_total_q    <= total_nx;
				end
				ST_FREED: begin
					count_q[cls_s1] <= count_q[cls_s1] + cnt_t'(1);
					if (fill_q[cls_s1] != cnt_t'(MAX_BLOCKS)) begin
						fill_q[cls_s1] <= fill_q[cls_s1] + cnt_t'(1);
					end
					free_total_q <= total_nx;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (retire) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (retire) begin
			status_q     <= status_s1;
			uaddr_q      <= uaddr_nx;
			cls_q        <= cls_s1;
			free_bytes_q <= total_nx;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = status_q;
	assign rsp.user_address = uaddr_q;
	assign rsp.size_class   = cls_q;
	assign rsp.free_bytes   = free_bytes_q;

	always_comb begin
		counts_ok = 1'b1;
		for (int c = 0; c < NUM_CLASSES; c++) begin
			if (count_q[c] > lay.blocks[c]) begin
				counts_ok = 1'b0;
			end
		end
	end

	assign rebuild_start = cfg.valid && cfg.ready && cfg.index < CFG_IDX_W'(CFG_REGS);
	assign alloc_out     = rsp.valid && rsp.status == ST_ALLOC;

	`SCLFL_ASSERT_NOW(a_counts_bounded, !lay.busy, counts_ok, "free count above class size")
	`SCLFL_ASSERT_NEXT(a_total_hold, !retire && !lay.busy, $stable(free_total_q), "free total moved")
	`SCLFL_ASSERT_NEXT(a_cfg_blocks_cmd, rebuild_start, !cmd.ready, "cmd open during rebuild")
	`SCLFL_ASSERT_NOW(a_alloc_align, alloc_out, rsp.user_address[3:0] == 4'd4, "misaligned address")

endmodule

### rtl/sclfl_ring_mem.sv
module sclfl_ring_mem import sclfl_pkg::*; (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [MEM_AW-1:0] rd_addr,
	output idx_t              rd_data,
	input  logic              wr_en,
	input  logic [MEM_AW-1:0] wr_addr,
	input  idx_t              wr_data
);

	// One ring of block indices per class, class in the upper address bits.
	idx_t mem [MEM_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/sclfl_layout.sv
module sclfl_layout import sclfl_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	sclfl_cfg_if.sink cfg,
	output layout_t lay
);

	logic [CFG_DATA_W-1:0]   cfg_q [CFG_REGS];
	cnt_t [NUM_CLASSES-1:0]  blocks;
	addr_t [NUM_CLASSES-1:0] base_q;
	addr_t [NUM_CLASSES-1:0] lim_q;
	addr_t                   acc_q;
	addr_t                   total_q;
	addr_t                   span;
	cls_t                    step_q;
	logic                    busy_q;
	logic                    cfg_hit;
	logic                    last_step;

	assign cfg.ready = 1'b1;
	assign cfg_hit   = cfg.valid && cfg.ready && (cfg.index < CFG_IDX_W'(CFG_REGS));
	assign last_step = (step_q == cls_t'(NUM_CLASSES - 1));

	// counts above the ring depth saturate
	always_comb begin
		blocks = '0;
		for (int c = 0; c < CFG_REGS; c++) begin
			blocks[c] = (cfg_q[c] > CFG_DATA_W'(MAX_BLOCKS)) ? cnt_t'(MAX_BLOCKS)
			                                                 : cnt_t'(cfg_q[c]);
		end
	end

	assign span = addr_t'(blocks[step_q]) << (MIN_SHIFT + int'(step_q));

	// One class per cycle: region start, region end, running total.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CFG_REGS; c++) begin
				cfg_q[c] <= '0;
			end
			base_q  <= '0;
			lim_q   <= '0;
			acc_q   <= '0;
			total_q <= '0;
			step_q  <= '0;
			busy_q  <= 1'b0;
		end else if (cfg_hit) begin
			cfg_q[cfg.index] <= cfg.data;
			acc_q            <= '0;
			step_q           <= '0;
			busy_q           <= 1'b1;
		end else if (busy_q) begin
			base_q[step_q] <= acc_q;
			lim_q[step_q]  <= acc_q + span;
			acc_q          <= acc_q + span;
			if (last_step) begin
				busy_q  <= 1'b0;
				total_q <= acc_q + span;
			end else begin
				step_q <= step_q + cls_t'(1);
			end
		end
	end

	always_comb begin
		lay.busy   = busy_q;
		lay.load   = busy_q && last_step;
		lay.total  = acc_q + span;
		lay.base   = base_q;
		lay.lim    = lim_q;
		lay.blocks = blocks;
		if (!busy_q) begin
			lay.total = total_q;
		end
	end

endmodule

### rtl/sclfl_decode.sv
module sclfl_decode import sclfl_pkg::*; (
	input  logic                   operation,
	input  logic [REQ_W-1:0]       request_size,
	input  addr_t                  block_address,
	input  layout_t                lay,
	input  idx_t [NUM_CLASSES-1:0] head,
	input  cnt_t [NUM_CLASSES-1:0] count,
	input  cnt_t [NUM_CLASSES-1:0] fill,
	output dec_t                   dec
);

	always_comb begin
		logic [REQ_W:0] need;
		addr_t          off;
		addr_t          rel;
		addr_t          size;
		idx_t           lag;
		cls_t           sel;
		logic           hit;

		dec  = '0;
		need = {1'b0, request_size} + (REQ_W + 1)'(HEADER_BYTES);
		off  = block_address - addr_t'(HEADER_BYTES);
		rel  = '0;
		size = '0;
		lag  = '0;
		sel  = '0;
		hit  = 1'b0;

		if (operation == OP_ALLOC) begin
			for (int c = 0; c < NUM_CLASSES; c++) begin
				if (!hit && class_size(cls_t'(c)) >= addr_t'(need) && count[c] != '0) begin
					hit = 1'b1;
					sel = cls_t'(c);
				end
			end
			if (request_size == '0) begin
				dec.status = ST_ZERO;
			end else if (hit) begin
				dec.status = ST_ALLOC;
				dec.cls    = sel;
				dec.pos    = head[sel];
				// ring slot already rewritten since the rebuild, else it still holds its own index
				lag         = head[sel] - lay.blocks[sel][IDX_W-1:0];
				dec.mem_hit = cnt_t'(lag) < fill[sel];
			end else begin
				dec.status = ST_NO_BLOCK;
			end
		end else begin
			dec.status = ST_BAD_ADDR;
			if (block_address >= addr_t'(HEADER_BYTES)) begin
				// region ends ascend, so the first end above the offset is the region
				for (int c = 0; c < NUM_CLASSES; c++) begin
					if (!hit && off < lay.lim[c]) begin
						hit = 1'b1;
						sel = cls_t'(c);
					end
				end
				if (hit) begin
					rel  = off - lay.base[sel];
					size = class_size(sel);
					if ((rel & (size - addr_t'(1))) == '0) begin
						dec.cls    = sel;
						dec.idx    = idx_t'(rel >> (MIN_SHIFT + int'(sel)));
						dec.pos    = head[sel] + count[sel][IDX_W-1:0];
						dec.status = (count[sel] >= lay.blocks[sel]) ? ST_FULL : ST_FREED;
					end
				end
			end
		end
	end

endmodule
